@@ hdl/lcasr_pkg.sv @@
// shared constants and types for the load cell adc serial reader
`default_nettype none

package lcasr_pkg;

  // converter and read limits
  localparam int unsigned NumSensors = 2;
  localparam int unsigned DataBits   = 24;
  localparam int unsigned PollLimit  = 100;

  // field widths
  localparam int unsigned IntervalW = 32;
  localparam int unsigned CountW    = 16;
  localparam int unsigned PulseW    = 5;
  localparam int unsigned TriesW    = 7;
  localparam int unsigned SensW     = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  // stream beat widths, padded to whole bytes
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSampleInterval = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSampleTotal    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPulseCount     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPollSpacing    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSensorCount    = 3'd5;

  // configuration reset values
  localparam logic [IntervalW-1:0] IntervalReset = 32'd100000000;
  localparam logic [CountW-1:0]    TotalReset    = 16'd0;
  localparam logic [PulseW-1:0]    PulseReset    = 5'd25;
  localparam logic [CountW-1:0]    HalfReset     = 16'd10;
  localparam logic [CountW-1:0]    PollReset     = 16'd10;
  localparam logic [SensW-1:0]     SensReset     = 2'd2;

  // sequencer phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhWait = 2'd1;
  localparam logic [1:0] PhHigh = 2'd2;
  localparam logic [1:0] PhLow  = 2'd3;

  // one input beat
  typedef struct packed {
    logic [1:0] dout_bits;
    logic       stop;
    logic       start_req;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [CountW-1:0]   sample_number;
    logic [DataBits-1:0] value_b;
    logic [DataBits-1:0] value_a;
    logic                timed_out;
    logic                sample_done;
    logic                sck;
  } out_item_t;

endpackage : lcasr_pkg

`default_nettype wire

@@ hdl/load_cell_adc_serial_reader.sv @@
// serial reader for up to two load cell converters sharing one serial clock
//
// Every input beat is one sequencer tick carrying start, stop and the sampled
// data pin levels; every accepted beat yields exactly one result beat with the
// serial clock level, a done strobe, a timeout flag, both readings and the
// count of reads finished since start.
// An input beat is captured in an input register; the tick is then evaluated
// in one pass and the result lands in an output register, from which it is
// offered to the receiver. One beat is accepted every cycle while the output
// side takes results.
// If the receiver stalls, the pending result holds, the input register fills
// and s_axis_tready drops until the result is taken; nothing is lost.
// Configuration writes are always ready and take effect at the next tick.
// Reset clears the sequencer, timers and counters and loads the register
// defaults (interval 100000000, total 0, 25 pulses, half period 10,
// poll spacing 10, two sensors).
`default_nettype none

module load_cell_adc_serial_reader (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lcasr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lcasr_pkg::CfgDataW-1:0] cfg_data_i,
  // tick input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: start_req, stop, dout_bits[1:0], zero pad
  input  wire logic [lcasr_pkg::InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: sck, sample_done, timed_out, value_a[23:0], value_b[23:0],
  //        sample_number[15:0], zero pad
  output logic [lcasr_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned DW = lcasr_pkg::DataBits;
  localparam int unsigned CW = lcasr_pkg::CountW;
  localparam int unsigned IW = lcasr_pkg::IntervalW;
  localparam int unsigned PW = lcasr_pkg::PulseW;
  localparam int unsigned TW = lcasr_pkg::TriesW;
  localparam int unsigned OutItemW = $bits(lcasr_pkg::out_item_t);

  // configuration registers
  logic [IW-1:0]                 interval_q;
  logic [CW-1:0]                 total_q;
  logic [PW-1:0]                 pulses_q;
  logic [CW-1:0]                 half_q;
  logic [CW-1:0]                 poll_q;
  logic [lcasr_pkg::SensW-1:0]   sens_q;

  // pipeline registers
  logic                          in_valid_q;
  lcasr_pkg::in_item_t           in_item_q;
  logic                          out_valid_q;
  lcasr_pkg::out_item_t          out_item_q, out_item_d;
  logic                          advance;

  // sequencer state
  logic [1:0]    phase_q, phase_d;
  logic [IW-1:0] itimer_q, itimer_d;
  logic [CW-1:0] left_q, left_d;
  logic          pend_q, pend_d;
  logic [PW-1:0] pidx_q, pidx_d;
  logic [CW-1:0] tick_q, tick_d;
  logic [TW-1:0] tries_q, tries_d;
  logic [DW-1:0] sh0_q, sh0_d, sh1_q, sh1_d;
  logic [CW-1:0] taken_q, taken_d;
  logic          clk_lvl_q, clk_lvl_d;

  // derived configuration
  logic          two_sensors;
  logic [1:0]    en_mask;
  logic [IW-1:0] interval_eff;
  logic [CW-1:0] half_reload, poll_reload;
  logic          done, tmo;

  assign cfg_ready_o = 1'b1;

  // zero counts as one sensor, three is cut to two
  assign two_sensors  = (sens_q >= 2'd2);
  assign en_mask      = two_sensors ? 2'b11 : 2'b01;
  assign interval_eff = (interval_q == '0) ? {{(IW-1){1'b0}}, 1'b1} : interval_q;
  assign half_reload  = (half_q == '0) ? '0 : half_q - 1'b1;
  assign poll_reload  = (poll_q == '0) ? '0 : poll_q - 1'b1;

  // handshake: input stage moves on when the output slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lcasr_pkg::OutDataW-OutItemW){1'b0}}, out_item_q};

  // one tick of the sequencer
  always_comb begin
    phase_d   = phase_q;
    itimer_d  = itimer_q;
    left_d    = left_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    tick_d    = tick_q;
    tries_d   = tries_q;
    sh0_d     = sh0_q;
    sh1_d     = sh1_q;
    taken_d   = taken_q;
    clk_lvl_d = clk_lvl_q;
    done      = 1'b0;
    tmo       = 1'b0;

    // interval timer and sample counting
    if (in_item_q.stop) begin
      left_d    = '0;
      pend_d    = 1'b0;
      itimer_d  = '0;
      phase_d   = lcasr_pkg::PhIdle;
      clk_lvl_d = 1'b0;
    end else if (in_item_q.start_req) begin
      itimer_d  = interval_eff;
      left_d    = total_q;
      taken_d   = '0;
      pend_d    = 1'b0;
      phase_d   = lcasr_pkg::PhIdle;
      clk_lvl_d = 1'b0;
    end else if (left_q != '0) begin
      if (itimer_q <= {{(IW-1){1'b0}}, 1'b1}) begin
        pend_d   = 1'b1;
        left_d   = left_q - 1'b1;
        itimer_d = (left_d != '0) ? interval_eff : '0;
      end else begin
        itimer_d = itimer_q - 1'b1;
      end
    end

    // read sequencer
    case (phase_d)
      lcasr_pkg::PhIdle: begin
        if (pend_d) begin
          pend_d    = 1'b0;
          sh0_d     = '0;
          sh1_d     = '0;
          tries_d   = '0;
          tick_d    = '0;
          pidx_d    = '0;
          clk_lvl_d = 1'b0;
          phase_d   = lcasr_pkg::PhWait;
        end
      end
      lcasr_pkg::PhWait: begin
        if (tick_d != '0) begin
          tick_d = tick_d - 1'b1;
        end else if ((in_item_q.dout_bits & en_mask) == 2'b00) begin
          if (pulses_q == '0) begin
            done = 1'b1;
          end else begin
            clk_lvl_d = 1'b1;
            pidx_d    = '0;
            tick_d    = half_reload;
            phase_d   = lcasr_pkg::PhHigh;
          end
        end else if (tries_d >= TW'(lcasr_pkg::PollLimit)) begin
          done = 1'b1;
          tmo  = 1'b1;
        end else begin
          tries_d = tries_d + 1'b1;
          tick_d  = poll_reload;
        end
      end
      lcasr_pkg::PhHigh: begin
        if (tick_d != '0) begin
          tick_d = tick_d - 1'b1;
        end else begin
          clk_lvl_d = 1'b0;
          tick_d    = half_reload;
          phase_d   = lcasr_pkg::PhLow;
        end
      end
      default: begin
        if (tick_d != '0) begin
          tick_d = tick_d - 1'b1;
        end else begin
          // sample the data pins at the end of the low half
          if (pidx_d < PW'(DW)) begin
            sh0_d = {sh0_d[DW-2:0], in_item_q.dout_bits[0]};
            if (two_sensors) begin
              sh1_d = {sh1_d[DW-2:0], in_item_q.dout_bits[1]};
            end
          end
          pidx_d = pidx_d + 1'b1;
          if (pidx_d >= pulses_q) begin
            done = 1'b1;
          end else begin
            clk_lvl_d = 1'b1;
            tick_d    = half_reload;
            phase_d   = lcasr_pkg::PhHigh;
          end
        end
      end
    endcase

    // finish the read: unless it timed out, flip the sign bit to offset binary
    if (done) begin
      if (!tmo) begin
        sh0_d[DW-1] = ~sh0_d[DW-1];
        if (two_sensors) begin
          sh1_d[DW-1] = ~sh1_d[DW-1];
        end
      end
      taken_d   = taken_d + 1'b1;
      phase_d   = lcasr_pkg::PhIdle;
      clk_lvl_d = 1'b0;
    end

    out_item_d.sck           = clk_lvl_d;
    out_item_d.sample_done   = done;
    out_item_d.timed_out     = tmo;
    out_item_d.value_a       = done ? sh0_d : '0;
    out_item_d.value_b       = done ? sh1_d : '0;
    out_item_d.sample_number = taken_d;
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= lcasr_pkg::IntervalReset;
      total_q    <= lcasr_pkg::TotalReset;
      pulses_q   <= lcasr_pkg::PulseReset;
      half_q     <= lcasr_pkg::HalfReset;
      poll_q     <= lcasr_pkg::PollReset;
      sens_q     <= lcasr_pkg::SensReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lcasr_pkg::CfgSampleInterval: interval_q <= cfg_data_i;
        lcasr_pkg::CfgSampleTotal:    total_q    <= cfg_data_i[CW-1:0];
        lcasr_pkg::CfgPulseCount:     pulses_q   <= cfg_data_i[PW-1:0];
        lcasr_pkg::CfgHalfPeriod:     half_q     <= cfg_data_i[CW-1:0];
        lcasr_pkg::CfgPollSpacing:    poll_q     <= cfg_data_i[CW-1:0];
        lcasr_pkg::CfgSensorCount:    sens_q     <= cfg_data_i[lcasr_pkg::SensW-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= s_axis_tdata[$bits(lcasr_pkg::in_item_t)-1:0];
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // sequencer state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lcasr_pkg::PhIdle;
      itimer_q  <= '0;
      left_q    <= '0;
      pend_q    <= 1'b0;
      pidx_q    <= '0;
      tick_q    <= '0;
      tries_q   <= '0;
      sh0_q     <= '0;
      sh1_q     <= '0;
      taken_q   <= '0;
      clk_lvl_q <= 1'b0;
    end else if (advance) begin
      phase_q   <= phase_d;
      itimer_q  <= itimer_d;
      left_q    <= left_d;
      pend_q    <= pend_d;
      pidx_q    <= pidx_d;
      tick_q    <= tick_d;
      tries_q   <= tries_d;
      sh0_q     <= sh0_d;
      sh1_q     <= sh1_d;
      taken_q   <= taken_d;
      clk_lvl_q <= clk_lvl_d;
    end
  end

endmodule : load_cell_adc_serial_reader

`default_nettype wire
